// File: design/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared widths, register codes, reset values and interface types of the
// polyrhythm beat scheduler.
// ----------------------------------------------------------------------------
package bps_pkg;

	localparam int LEN_W   = 24;
	localparam int POS_W   = 25;
	localparam int STEP_W  = 5;
	localparam int IDX_W   = 4;
	localparam int MASK_W  = 16;
	localparam int BLK_W   = 13;
	localparam int HOST_W  = 48;
	localparam int SOUND_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int DIVD_W  = HOST_W;
	localparam int CNT_W   = $clog2(DIVD_W + 1);

	localparam int MAX_STEPS_DEF = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BAR_LENGTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_STEPS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_STEPS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_INTV  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_INTV = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_MASK  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_MASK = 3'd6;

	localparam logic [LEN_W-1:0]  RST_BAR_LENGTH  = 24'd96000;
	localparam logic [STEP_W-1:0] RST_FIRST_STEPS = 5'd4;
	localparam logic [STEP_W-1:0] RST_SECOND_STEPS = 5'd3;
	localparam logic [LEN_W-1:0]  RST_FIRST_INTV  = 24'd24000;
	localparam logic [LEN_W-1:0]  RST_SECOND_INTV = 24'd32000;
	localparam logic [MASK_W-1:0] RST_MASK        = 16'hFFFF;

	localparam logic [SOUND_W-1:0] SOUND_NONE = 2'd0;
	localparam logic [SOUND_W-1:0] SOUND_LOW  = 2'd1;
	localparam logic [SOUND_W-1:0] SOUND_HIGH = 2'd2;
	localparam logic [SOUND_W-1:0] SOUND_SUB  = 2'd3;

	typedef struct packed {
		logic              start;
		logic [CNT_W-1:0]  nbits;
		logic [DIVD_W-1:0] dividend;
		logic [LEN_W-1:0]  divisor;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [LEN_W-1:0] rem;
	} mod_rsp_t;

	typedef struct packed {
		logic [BLK_W-1:0]  block_size;
		logic [LEN_W-1:0]  ph1;
		logic [LEN_W-1:0]  ph2;
		logic [LEN_W-1:0]  i1;
		logic [LEN_W-1:0]  i2;
		logic [STEP_W:0]   s1;
		logic [STEP_W:0]   s2;
		logic [STEP_W-1:0] count1;
		logic [STEP_W-1:0] count2;
		logic [MASK_W-1:0] mask1;
		logic [MASK_W-1:0] mask2;
	} tick_in_t;

	typedef struct packed {
		logic [SOUND_W-1:0] sound;
		logic               note1;
		logic               note2;
		logic [BLK_W-1:0]   offset;
		logic [STEP_W-1:0]  count1;
		logic [STEP_W-1:0]  count2;
	} tick_out_t;

endpackage

// File: design/bps_mod_unit.sv
// ----------------------------------------------------------------------------
// bps_mod_unit
// Shared restoring remainder unit: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module bps_mod_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  bps_pkg::mod_req_t req,
	output bps_pkg::mod_rsp_t rsp
);
	import bps_pkg::*;

	logic [DIVD_W-1:0] sh_q;
	logic [LEN_W-1:0]  rem_q;
	logic [LEN_W-1:0]  divisor_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [LEN_W:0] trial;
	logic [LEN_W:0] diff;
	logic [LEN_W-1:0] rem_next;

	assign trial = {rem_q, sh_q[DIVD_W-1]};
	assign diff = trial - {1'b0, divisor_q};
	assign rem_next = (trial >= {1'b0, divisor_q}) ? diff[LEN_W-1:0] : trial[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sh_q      <= req.dividend;
			divisor_q <= req.divisor;
			rem_q     <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[DIVD_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

// File: design/bps_tick_logic.sv
// ----------------------------------------------------------------------------
// bps_tick_logic
// Beat detection, step advance, enable gating and tick selection.
// ----------------------------------------------------------------------------
module bps_tick_logic (
	input  bps_pkg::tick_in_t  ti,
	output bps_pkg::tick_out_t to
);
	import bps_pkg::*;

	logic [POS_W-1:0]  sum1;
	logic [POS_W-1:0]  sum2;
	logic              f1;
	logic              f2;
	logic [STEP_W-1:0] c1;
	logic [STEP_W-1:0] c2;
	logic [STEP_W-1:0] a1;
	logic [STEP_W-1:0] a2;
	logic [STEP_W:0]   inc1;
	logic [STEP_W:0]   inc2;
	logic              e1;
	logic              e2;
	logic [LEN_W-1:0]  off1;
	logic [LEN_W-1:0]  off2;

	function automatic logic enabled(input logic [MASK_W-1:0] mask,
			input logic [STEP_W-1:0] idx);
		logic r;
		r = 1'b0;
		if (idx < STEP_W'(MASK_W))
			r = mask[idx[IDX_W-1:0]];
		return r;
	endfunction

	always_comb begin
		sum1 = {1'b0, ti.ph1} + POS_W'(ti.block_size);
		sum2 = {1'b0, ti.ph2} + POS_W'(ti.block_size);
		f1 = (sum1 >= {1'b0, ti.i1}) && (ti.s1 > (STEP_W+1)'(1));
		f2 = (sum2 >= {1'b0, ti.i2}) && (ti.s2 > (STEP_W+1)'(1));

		c1 = ({1'b0, ti.count1} >= ti.s1) ? '0 : ti.count1;
		c2 = ({1'b0, ti.count2} >= ti.s2) ? '0 : ti.count2;
		inc1 = {1'b0, c1} + 1'b1;
		inc2 = {1'b0, c2} + 1'b1;
		a1 = (inc1 >= ti.s1) ? '0 : inc1[STEP_W-1:0];
		a2 = (inc2 >= ti.s2) ? '0 : inc2[STEP_W-1:0];
		e1 = enabled(ti.mask1, a1);
		e2 = enabled(ti.mask2, a2);
		off1 = ti.i1 - ti.ph1;
		off2 = ti.i2 - ti.ph2;

		to.sound  = SOUND_NONE;
		to.note1  = 1'b0;
		to.note2  = 1'b0;
		to.offset = '0;
		to.count1 = c1;
		to.count2 = c2;
		if (f1 && f2) begin
			to.count1 = a1;
			to.count2 = a2;
			if (e1 || e2) begin
				to.offset = off1[BLK_W-1:0];
				to.note1  = e1;
				to.note2  = e2;
				to.sound  = (e1 && e2) ? SOUND_HIGH : (e1 ? SOUND_LOW : SOUND_SUB);
			end
		end else if (f1) begin
			to.count1 = a1;
			if (e1) begin
				to.sound  = SOUND_LOW;
				to.note1  = 1'b1;
				to.offset = off1[BLK_W-1:0];
			end
		end else if (f2) begin
			to.count2 = a2;
			if (e2) begin
				to.sound  = SOUND_SUB;
				to.note2  = 1'b1;
				to.offset = off2[BLK_W-1:0];
			end
		end
	end

endmodule

// File: design/polyrhythm_beat_scheduler_core.sv
// ----------------------------------------------------------------------------
// polyrhythm_beat_scheduler_core
// Polyrhythm beat scheduler: one request per audio block, one result each.
// The serial remainder unit works on the 48-bit host position when the host
// position is used, and on the 25-bit bar position for each rhythm phase.
// A new request is taken only once the previous result is registered and
// the block is back in idle.
// Asynchronous active-low reset loads the register defaults and clears state.
// ----------------------------------------------------------------------------
module polyrhythm_beat_scheduler_core #(
	parameter int MAX_STEPS = bps_pkg::MAX_STEPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bps_pkg::LEN_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bps_pkg::BLK_W-1:0]      block_size,
	input  logic                           host_connected,
	input  logic                           host_playing,
	input  logic [bps_pkg::HOST_W-1:0]     host_position,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bps_pkg::SOUND_W-1:0]    tick_sound,
	output logic                           first_note,
	output logic                           second_note,
	output logic [bps_pkg::BLK_W-1:0]      start_offset,
	output logic [bps_pkg::IDX_W-1:0]      first_step_index,
	output logic [bps_pkg::IDX_W-1:0]      second_step_index
);
	import bps_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HOST = 3'd1;
	localparam logic [2:0] ST_PH1  = 3'd2;
	localparam logic [2:0] ST_PH2  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;
	localparam logic [STEP_W:0] STEP_CAP = (STEP_W+1)'(MAX_STEPS);

	logic [2:0]        state_q;
	logic              launch_q;
	logic [LEN_W-1:0]  bar_length_q;
	logic [STEP_W-1:0] first_steps_q;
	logic [STEP_W-1:0] second_steps_q;
	logic [LEN_W-1:0]  first_intv_q;
	logic [LEN_W-1:0]  second_intv_q;
	logic [MASK_W-1:0] first_mask_q;
	logic [MASK_W-1:0] second_mask_q;
	logic [POS_W-1:0]  bar_pos_q;
	logic [STEP_W-1:0] count1_q;
	logic [STEP_W-1:0] count2_q;
	logic [BLK_W-1:0]  bs_q;
	logic              playing_q;
	logic [HOST_W-1:0] host_q;
	logic [LEN_W-1:0]  ph1_q;
	logic [LEN_W-1:0]  ph2_q;
	logic              out_valid_q;
	logic [SOUND_W-1:0] sound_q;
	logic              note1_q;
	logic              note2_q;
	logic [BLK_W-1:0]  offset_q;

	logic [LEN_W-1:0]  bar;
	logic [LEN_W-1:0]  i1;
	logic [LEN_W-1:0]  i2;
	logic [POS_W-1:0]  pos_after;
	logic              slot_free;
	mod_req_t          mreq;
	mod_rsp_t          mrsp;
	tick_in_t          ti;
	tick_out_t         to;

	function automatic logic [LEN_W-1:0] at_least_one(input logic [LEN_W-1:0] v);
		return (v == '0) ? LEN_W'(1) : v;
	endfunction

	function automatic logic [STEP_W:0] eff_steps(input logic [STEP_W-1:0] s);
		return ({1'b0, s} > STEP_CAP) ? STEP_CAP : {1'b0, s};
	endfunction

	assign bar = at_least_one(bar_length_q);
	assign i1  = at_least_one(first_intv_q);
	assign i2  = at_least_one(second_intv_q);
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		mreq.start    = launch_q;
		mreq.nbits    = CNT_W'(POS_W);
		mreq.dividend = {bar_pos_q, {(DIVD_W-POS_W){1'b0}}};
		mreq.divisor  = i1;
		case (state_q)
			ST_HOST: begin
				mreq.nbits    = CNT_W'(HOST_W);
				mreq.dividend = host_q;
				mreq.divisor  = bar;
			end
			ST_PH2: begin
				mreq.divisor = i2;
			end
			default: begin
				mreq.divisor = i1;
			end
		endcase
	end

	bps_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	always_comb begin
		ti.block_size = bs_q;
		ti.ph1    = ph1_q;
		ti.ph2    = ph2_q;
		ti.i1     = i1;
		ti.i2     = i2;
		ti.s1     = eff_steps(first_steps_q);
		ti.s2     = eff_steps(second_steps_q);
		ti.count1 = count1_q;
		ti.count2 = count2_q;
		ti.mask1  = first_mask_q;
		ti.mask2  = second_mask_q;
	end

	bps_tick_logic u_tick (
		.ti (ti),
		.to (to)
	);

	assign pos_after = (bar_pos_q >= {1'b0, bar} && !playing_q) ?
		(bar_pos_q - {1'b0, bar}) : bar_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			launch_q       <= 1'b0;
			out_valid_q    <= 1'b0;
			bar_length_q   <= RST_BAR_LENGTH;
			first_steps_q  <= RST_FIRST_STEPS;
			second_steps_q <= RST_SECOND_STEPS;
			first_intv_q   <= RST_FIRST_INTV;
			second_intv_q  <= RST_SECOND_INTV;
			first_mask_q   <= RST_MASK;
			second_mask_q  <= RST_MASK;
			bar_pos_q      <= '0;
			count1_q       <= '0;
			count2_q       <= '0;
		end else begin
			launch_q <= 1'b0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						launch_q <= 1'b1;
						if (host_connected || host_playing) begin
							state_q <= ST_HOST;
						end else begin
							bar_pos_q <= bar_pos_q + POS_W'(block_size);
							state_q   <= ST_PH1;
						end
					end
				end
				ST_HOST: begin
					if (mrsp.done) begin
						bar_pos_q <= POS_W'(mrsp.rem) + POS_W'(bs_q);
						launch_q  <= 1'b1;
						state_q   <= ST_PH1;
					end
				end
				ST_PH1: begin
					if (mrsp.done) begin
						launch_q <= 1'b1;
						state_q  <= ST_PH2;
					end
				end
				ST_PH2: begin
					if (mrsp.done)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						count1_q    <= to.count1;
						count2_q    <= to.count2;
						bar_pos_q   <= pos_after;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_write) begin
				case (cfg_index)
					REG_BAR_LENGTH: bar_length_q <= cfg_data;
					REG_FIRST_STEPS: begin
						if (cfg_data[STEP_W-1:0] != first_steps_q) begin
							first_steps_q <= cfg_data[STEP_W-1:0];
							bar_pos_q <= '0;
							count1_q  <= '0;
							count2_q  <= '0;
						end
					end
					REG_SECOND_STEPS: begin
						if (cfg_data[STEP_W-1:0] != second_steps_q) begin
							second_steps_q <= cfg_data[STEP_W-1:0];
							bar_pos_q <= '0;
							count1_q  <= '0;
							count2_q  <= '0;
						end
					end
					REG_FIRST_INTV:  first_intv_q  <= cfg_data;
					REG_SECOND_INTV: second_intv_q <= cfg_data;
					REG_FIRST_MASK:  first_mask_q  <= cfg_data[MASK_W-1:0];
					REG_SECOND_MASK: second_mask_q <= cfg_data[MASK_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			bs_q      <= block_size;
			playing_q <= host_playing;
			host_q    <= host_position;
		end
		if (state_q == ST_PH1 && mrsp.done)
			ph1_q <= mrsp.rem;
		if (state_q == ST_PH2 && mrsp.done)
			ph2_q <= mrsp.rem;
		if (state_q == ST_OUT && slot_free) begin
			sound_q  <= to.sound;
			note1_q  <= to.note1;
			note2_q  <= to.note2;
			offset_q <= to.offset;
		end
	end

	assign out_valid         = out_valid_q;
	assign tick_sound        = sound_q;
	assign first_note        = note1_q;
	assign second_note       = note2_q;
	assign start_offset      = offset_q;
	assign first_step_index  = count1_q[IDX_W-1:0];
	assign second_step_index = count2_q[IDX_W-1:0];

endmodule

// File: design/bps_checker.sv
// ----------------------------------------------------------------------------
// bps_checker
// Port-level checks of the beat scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module bps_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [bps_pkg::SOUND_W-1:0]   tick_sound,
	input logic                          first_note,
	input logic                          second_note,
	input logic [bps_pkg::BLK_W-1:0]     start_offset
);
	import bps_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while still busy");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tick_sound) &&
		$stable(start_offset))
		else $error("stalled result changed");

	a_silent_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tick_sound == SOUND_NONE |->
		!first_note && !second_note && start_offset == '0)
		else $error("silent result carries note or offset");

	a_low_tick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tick_sound == SOUND_LOW |-> first_note && !second_note)
		else $error("low tick with wrong note flags");

	a_high_tick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tick_sound == SOUND_HIGH |-> first_note && second_note)
		else $error("coincident tick without both notes");

endmodule

bind polyrhythm_beat_scheduler_core bps_checker u_bps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.tick_sound   (tick_sound),
	.first_note   (first_note),
	.second_note  (second_note),
	.start_offset (start_offset)
);

// File: tb/tb_polyrhythm_beat_scheduler_core.sv
// ----------------------------------------------------------------------------
// tb_polyrhythm_beat_scheduler_core
// Self-checking bench for the polyrhythm beat scheduler. A short directed
// sequence covers the reset settings, the field extremes and the odd register
// values. Sixteen phases follow, each with a register setting, random after
// the first, and one of four mixes of source gaps and sink stalls. Every
// request is scored in order against a cycle-free scheduler model.
// ----------------------------------------------------------------------------
module tb_polyrhythm_beat_scheduler_core;
	timeunit 1ns;
	timeprecision 1ps;

	import bps_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 500;
	localparam int PHASE_BLOCKS   = 115;
	localparam logic [STEP_W-1:0] ODD_STEPS [5] = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};
	localparam logic [BLK_W-1:0] SHORT_BLOCKS [10] =
		'{13'd1, 13'd5, 13'd6, 13'd12, 13'd24, 13'd4096, 13'd11, 13'd13, 13'd48, 13'd7};

	typedef struct packed {
		logic [BLK_W-1:0]  block_size;
		logic              connected;
		logic              playing;
		logic [HOST_W-1:0] host_position;
	} block_req_t;

	typedef struct packed {
		logic [SOUND_W-1:0] sound;
		logic               first_note;
		logic               second_note;
		logic [BLK_W-1:0]   offset;
		logic [IDX_W-1:0]   first_idx;
		logic [IDX_W-1:0]   second_idx;
	} beat_result_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LEN_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [BLK_W-1:0]     block_size = '0;
	logic                 host_connected = 1'b0;
	logic                 host_playing = 1'b0;
	logic [HOST_W-1:0]    host_position = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [SOUND_W-1:0]   tick_sound;
	logic                 first_note;
	logic                 second_note;
	logic [BLK_W-1:0]     start_offset;
	logic [IDX_W-1:0]     first_step_index;
	logic [IDX_W-1:0]     second_step_index;

	// Scheduler model state and its copy of the registers.
	logic [LEN_W-1:0]  bar_length_r = RST_BAR_LENGTH;
	logic [STEP_W-1:0] steps1_r = RST_FIRST_STEPS;
	logic [STEP_W-1:0] steps2_r = RST_SECOND_STEPS;
	logic [LEN_W-1:0]  interval1_r = RST_FIRST_INTV;
	logic [LEN_W-1:0]  interval2_r = RST_SECOND_INTV;
	logic [MASK_W-1:0] mask1_r = RST_MASK;
	logic [MASK_W-1:0] mask2_r = RST_MASK;
	logic [POS_W-1:0]  bar_pos_r = '0;
	logic [STEP_W-1:0] count1_r = '0;
	logic [STEP_W-1:0] count2_r = '0;

	block_req_t   pending_blocks [$];
	beat_result_t expected_beats [$];
	block_req_t   next_block;
	beat_result_t got, want;

	int requests_queued = 0;
	int requests_offered = 0;
	int requests_taken = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_armed = 1'b0;
	int hold_left = HOLD_CYCLES;

	polyrhythm_beat_scheduler_core DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic beat_result_t schedule_block(block_req_t rq);
		beat_result_t r;
		int unsigned bar, i1, i2, s1, s2, ph1, ph2, bs;
		logic hit1, hit2, en1, en2;
		bs  = rq.block_size;
		bar = (bar_length_r == 0) ? 1 : bar_length_r;
		i1  = (interval1_r == 0) ? 1 : interval1_r;
		i2  = (interval2_r == 0) ? 1 : interval2_r;
		s1  = (steps1_r > MAX_STEPS_DEF) ? MAX_STEPS_DEF : steps1_r;
		s2  = (steps2_r > MAX_STEPS_DEF) ? MAX_STEPS_DEF : steps2_r;
		r = '0;
		if (!rq.connected && !rq.playing)
			bar_pos_r = POS_W'(bar_pos_r + bs);
		else
			bar_pos_r = POS_W'(32'(rq.host_position % bar) + bs);
		ph1 = bar_pos_r % i1;
		ph2 = bar_pos_r % i2;
		hit1 = (ph1 + bs >= i1) && (s1 > 1);
		hit2 = (ph2 + bs >= i2) && (s2 > 1);
		if (count1_r >= s1)
			count1_r = '0;
		if (count2_r >= s2)
			count2_r = '0;
		if (hit1)
			count1_r = (count1_r + 1 >= s1) ? '0 : STEP_W'(count1_r + 1);
		if (hit2)
			count2_r = (count2_r + 1 >= s2) ? '0 : STEP_W'(count2_r + 1);
		en1 = hit1 && (count1_r < MASK_W) && mask1_r[count1_r[IDX_W-1:0]];
		en2 = hit2 && (count2_r < MASK_W) && mask2_r[count2_r[IDX_W-1:0]];
		if (en1 || en2) begin
			r.first_note  = en1;
			r.second_note = en2;
			r.offset = BLK_W'(hit1 ? i1 - ph1 : i2 - ph2);
			if (en1 && en2)
				r.sound = SOUND_HIGH;
			else if (en1)
				r.sound = SOUND_LOW;
			else
				r.sound = SOUND_SUB;
		end else begin
			r.sound = SOUND_NONE;
		end
		if (bar_pos_r >= bar && !rq.playing)
			bar_pos_r = POS_W'(bar_pos_r - bar);
		r.first_idx  = count1_r[IDX_W-1:0];
		r.second_idx = count2_r[IDX_W-1:0];
		return r;
	endfunction

	function automatic void clear_counts();
		bar_pos_r = '0;
		count1_r  = '0;
		count2_r  = '0;
	endfunction

	function automatic string beat_text(beat_result_t b);
		return $sformatf("sound %0d notes %0b/%0b offset %0d steps %0d/%0d",
			b.sound, b.first_note, b.second_note, b.offset, b.first_idx, b.second_idx);
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_BAR_LENGTH: bar_length_r = data;
			REG_FIRST_STEPS: begin
				if (data[STEP_W-1:0] != steps1_r) begin
					steps1_r = data[STEP_W-1:0];
					clear_counts();
				end
			end
			REG_SECOND_STEPS: begin
				if (data[STEP_W-1:0] != steps2_r) begin
					steps2_r = data[STEP_W-1:0];
					clear_counts();
				end
			end
			REG_FIRST_INTV:  interval1_r = data;
			REG_SECOND_INTV: interval2_r = data;
			REG_FIRST_MASK:  mask1_r = data[MASK_W-1:0];
			REG_SECOND_MASK: mask2_r = data[MASK_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic apply_setting(logic [LEN_W-1:0] bar, logic [STEP_W-1:0] s1,
			logic [STEP_W-1:0] s2, logic [LEN_W-1:0] i1, logic [LEN_W-1:0] i2,
			logic [MASK_W-1:0] k1, logic [MASK_W-1:0] k2);
		write_reg(REG_BAR_LENGTH, bar);
		write_reg(REG_FIRST_STEPS, {(LEN_W-STEP_W)'($urandom), s1});
		write_reg(REG_SECOND_STEPS, {(LEN_W-STEP_W)'($urandom), s2});
		write_reg(REG_FIRST_INTV, i1);
		write_reg(REG_SECOND_INTV, i2);
		write_reg(REG_FIRST_MASK, {(LEN_W-MASK_W)'($urandom), k1});
		write_reg(REG_SECOND_MASK, {(LEN_W-MASK_W)'($urandom), k2});
	endtask

	task automatic random_setting();
		logic [LEN_W-1:0]  bar, i1, i2;
		logic [STEP_W-1:0] s1, s2;
		logic [MASK_W-1:0] k1, k2;
		int kind;
		kind = $urandom_range(9);
		s1 = STEP_W'($urandom_range(1, 16));
		s2 = STEP_W'($urandom_range(1, 16));
		k1 = ($urandom_range(3) == 0) ? '1 : MASK_W'($urandom);
		k2 = ($urandom_range(3) == 0) ? '1 : MASK_W'($urandom);
		case (kind)
			0, 1, 2, 3, 4, 5: bar = LEN_W'($urandom_range(16, 6000));
			6: bar = LEN_W'($urandom_range(100000, 24'hFFFFFF));
			default: bar = LEN_W'($urandom_range(1, 200));
		endcase
		i1 = (bar / s1 == 0) ? LEN_W'(1) : bar / s1;
		i2 = (bar / s2 == 0) ? LEN_W'(1) : bar / s2;
		if (kind == 7) begin
			i1 = LEN_W'($urandom_range(1, 3000));
			i2 = LEN_W'($urandom_range(1, 3000));
		end
		if (kind == 8) begin
			s1  = ODD_STEPS[$urandom_range(4)];
			s2  = ODD_STEPS[$urandom_range(4)];
			bar = $urandom_range(1) ? '1 : '0;
			i1  = $urandom_range(1) ? LEN_W'($urandom_range(1, 4)) : '0;
			i2  = $urandom_range(1) ? '1 : '0;
		end
		apply_setting(bar, s1, s2, i1, i2, k1, k2);
	endtask

	task automatic queue_block(logic [BLK_W-1:0] bs, logic conn, logic play,
			logic [HOST_W-1:0] host);
		pending_blocks.push_back('{bs, conn, play, host});
		requests_queued++;
	endtask

	// Mostly coherent runs: a free-running stream, or a host transport whose
	// position advances by the block size; a few runs are pure noise.
	task automatic fill_phase(int n);
		logic [BLK_W-1:0]  bs;
		logic [HOST_W-1:0] host;
		logic conn, play;
		int left, run, kind, bs_mode;
		left = n;
		while (left > 0) begin
			kind = $urandom_range(9);
			run = $urandom_range(4, 20);
			if (run > left)
				run = left;
			bs_mode = $urandom_range(3);
			bs = BLK_W'($urandom_range(1, 4096));
			host = ($urandom_range(7) == 0) ? HOST_W'(-$urandom_range(1, 8192))
				: {16'($urandom), $urandom};
			conn = 1'b0;
			play = 1'b0;
			if (kind >= 7 && kind < 9) begin
				conn = $urandom_range(1);
				play = conn ? $urandom_range(1) : 1'b1;
			end
			for (int k = 0; k < run; k++) begin
				if (kind == 9) begin
					conn = $urandom_range(1);
					play = $urandom_range(1);
				end
				if (kind < 7 || kind == 9)
					host = {16'($urandom), $urandom};
				case (bs_mode)
					0: bs = BLK_W'($urandom_range(1, 4096));
					1: bs = BLK_W'($urandom_range(1, 64));
					2: ;
					default: bs = ($urandom_range(15) == 0) ? 13'd4096
						: BLK_W'($urandom_range(1, 512));
				endcase
				queue_block(bs, conn, play, host);
				host = host + bs;
			end
			left -= run;
		end
	endtask

	task automatic wait_idle();
		while (requests_taken != requests_queued || expected_beats.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (requests_taken == requests_offered) begin
			if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_block = pending_blocks.pop_front();
				in_valid       <= 1'b1;
				block_size     <= next_block.block_size;
				host_connected <= next_block.connected;
				host_playing   <= next_block.playing;
				host_position  <= next_block.host_position;
				requests_offered++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_armed && hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_beats.push_back(schedule_block(
					{block_size, host_connected, host_playing, host_position}));
				requests_taken <= requests_taken + 1;
			end
			if (out_valid && out_ready) begin
				got = {tick_sound, first_note, second_note, start_offset,
					first_step_index, second_step_index};
				if (expected_beats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: %s", beat_text(got));
				end else begin
					want = expected_beats.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch at %0t: expected %s, got %s",
								$realtime, beat_text(want), beat_text(got));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: long blocks reach both first beats, then host modes.
		repeat (7) queue_block(13'd4096, 1'b0, 1'b0, '0);
		queue_block(13'd1, 1'b1, 1'b0, '1);
		queue_block(13'd1, 1'b0, 1'b1, '0);
		queue_block(13'd4096, 1'b1, 1'b1, 48'd95999);
		wait_idle();

		// Short bar so that coincident beats, gating and step wrap show up.
		apply_setting(24'd48, 5'd4, 5'd3, 24'd12, 24'd16, 16'h000D, 16'hFFFF);
		foreach (SHORT_BLOCKS[k])
			queue_block(SHORT_BLOCKS[k], 1'b0, 1'b0, {16'($urandom), $urandom});
		wait_idle();

		// Zero lengths, step counts above the limit and disabled rhythms.
		apply_setting(24'd0, 5'd31, 5'd0, 24'd0, 24'd0, 16'hFFFF, 16'h0000);
		queue_block(13'd1, 1'b0, 1'b0, '0);
		queue_block(13'd3, 1'b0, 1'b0, '1);
		wait_idle();
		apply_setting(24'd1, 5'd1, 5'd17, 24'd1, 24'd2, 16'h0000, 16'hAAAA);
		queue_block(13'd2, 1'b0, 1'b0, '0);
		queue_block(13'd4096, 1'b1, 1'b0, '1);

		for (int p = 0; p < 16; p++) begin
			wait_idle();
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			if (p == 0)
				apply_setting('1, 5'd16, 5'd16, '1, '1, '1, '1);
			else
				random_setting();
			if (p == 4)
				hold_armed = 1'b1;
			fill_phase(PHASE_BLOCKS);
		end

		wait_idle();
		repeat (150) @(negedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: filelist.f
design/bps_pkg.sv
design/bps_mod_unit.sv
design/bps_tick_logic.sv
design/polyrhythm_beat_scheduler_core.sv
design/bps_checker.sv
tb/tb_polyrhythm_beat_scheduler_core.sv
